>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tdf_pkg.sv
// Types and constants shared by the trial division factorizer modules.
package tdf_pkg;

  localparam int PRIME_WIDTH    = 40;
  localparam int EXP_WIDTH      = 6;
  localparam int STATUS_WIDTH   = 2;
  localparam int MAX_RESULTS    = 11;
  localparam int RES_CNT_WIDTH  = 4;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_NONE    = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_TEST,
    ST_DIV,
    ST_REDIV,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic take_quotient;
    logic next_d;
    logic emit_factor;
    logic emit_cofactor;
    logic emit_none;
    logic emit_invalid;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rest_zero;
    logic rest_one;
    logic sq_gt_rest;
    logic div_done;
    logic rem_zero;
    logic cnt_nonzero;
    logic last_factor;
  } dp_status_t;

endpackage

>>> hw/rtl/tdf_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tdf_div #(
  parameter int VALUE_WIDTH = 40,
  parameter int DIV_WIDTH   = 21
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [DIV_WIDTH-1:0]   divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIV_WIDTH-1:0]   remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [DIV_WIDTH-1:0]   rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [CW-1:0]          count;
  logic [DIV_WIDTH:0]     shifted;
  logic [DIV_WIDTH:0]     trial;

  assign shifted = {rem, quo[VALUE_WIDTH-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= dividend;
        count <= CW'(VALUE_WIDTH);
      end else if (count != '0) begin
        if (!trial[DIV_WIDTH]) begin
          rem <= trial[DIV_WIDTH-1:0];
        end else begin
          rem <= shifted[DIV_WIDTH-1:0];
        end
        quo   <= {quo[VALUE_WIDTH-2:0], ~trial[DIV_WIDTH]};
        count <= count - 1'b1;
        done  <= (count == CW'(1));
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> hw/rtl/tdf_datapath.sv
// Datapath holding the reduced value, the candidate divisor and the result registers.
module tdf_datapath #(
  parameter int VALUE_WIDTH = 40,
  parameter int DIV_WIDTH   = 21
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tdf_pkg::ctrl_cmd_t            cmd,
  output tdf_pkg::dp_status_t           stat,
  input  logic [VALUE_WIDTH-1:0]        value,
  input  logic                          div_done,
  input  logic [VALUE_WIDTH-1:0]        quotient,
  input  logic [DIV_WIDTH-1:0]          remainder,
  output logic [VALUE_WIDTH-1:0]        dividend,
  output logic [DIV_WIDTH-1:0]          divisor,
  output logic                          valid,
  output logic [tdf_pkg::PRIME_WIDTH-1:0]  prime,
  output logic [tdf_pkg::EXP_WIDTH-1:0]    exponent,
  output logic [tdf_pkg::STATUS_WIDTH-1:0] status,
  output logic                          last
);

  logic [VALUE_WIDTH-1:0]            rest;
  logic [DIV_WIDTH-1:0]              d;
  logic [VALUE_WIDTH:0]              sq;
  logic [tdf_pkg::EXP_WIDTH-1:0]     cnt;
  logic [tdf_pkg::RES_CNT_WIDTH-1:0] n;
  logic [63:0]                       d_wide;
  logic [63:0]                       rest_wide;

  assign d_wide    = 64'(d);
  assign rest_wide = 64'(rest);

  assign stat.rest_zero   = (rest == '0);
  assign stat.rest_one    = (rest == VALUE_WIDTH'(1));
  assign stat.sq_gt_rest  = (sq > {1'b0, rest});
  assign stat.div_done    = div_done;
  assign stat.rem_zero    = (remainder == '0);
  assign stat.cnt_nonzero = (cnt != '0);
  assign stat.last_factor = (rest == VALUE_WIDTH'(1)) ||
                            (n == tdf_pkg::RES_CNT_WIDTH'(tdf_pkg::MAX_RESULTS - 1));

  assign dividend = rest;
  assign divisor  = d;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest <= value;
      d    <= DIV_WIDTH'(2);
      sq   <= (VALUE_WIDTH + 1)'(4);
      cnt  <= '0;
      n    <= '0;
    end else begin
      if (cmd.take_quotient) begin
        rest <= quotient;
        cnt  <= cnt + 1'b1;
      end
      if (cmd.emit_factor) begin
        cnt <= '0;
        n   <= n + 1'b1;
      end
      if (cmd.next_d) begin
        d  <= d + 1'b1;
        sq <= sq + {(VALUE_WIDTH - DIV_WIDTH)'(0), d, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit_factor | cmd.emit_cofactor | cmd.emit_none | cmd.emit_invalid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_factor) begin
      prime    <= d_wide[tdf_pkg::PRIME_WIDTH-1:0];
      exponent <= cnt;
      status   <= tdf_pkg::STATUS_OK;
      last     <= stat.last_factor;
    end else if (cmd.emit_cofactor) begin
      prime    <= rest_wide[tdf_pkg::PRIME_WIDTH-1:0];
      exponent <= tdf_pkg::EXP_WIDTH'(1);
      status   <= tdf_pkg::STATUS_OK;
      last     <= 1'b1;
    end else if (cmd.emit_none || cmd.emit_invalid) begin
      prime    <= '0;
      exponent <= '0;
      status   <= cmd.emit_none ? tdf_pkg::STATUS_NONE : tdf_pkg::STATUS_INVALID;
      last     <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/tdf_ctrl.sv
// Controller state machine that sequences candidate tests, divisions and result emission.
module tdf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tdf_pkg::dp_status_t stat,
  output tdf_pkg::ctrl_cmd_t  cmd
);

  tdf_pkg::state_t state;
  tdf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != tdf_pkg::ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      tdf_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = tdf_pkg::ST_CLASSIFY;
        end
      end
      tdf_pkg::ST_CLASSIFY: begin
        priority if (stat.rest_zero) begin
          cmd.emit_invalid = 1'b1;
          state_next       = tdf_pkg::ST_IDLE;
        end else if (stat.rest_one) begin
          cmd.emit_none = 1'b1;
          state_next    = tdf_pkg::ST_IDLE;
        end else begin
          state_next = tdf_pkg::ST_TEST;
        end
      end
      tdf_pkg::ST_TEST: begin
        if (stat.sq_gt_rest) begin
          state_next = tdf_pkg::ST_FINAL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = tdf_pkg::ST_DIV;
        end
      end
      tdf_pkg::ST_DIV: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            cmd.take_quotient = 1'b1;
            state_next        = tdf_pkg::ST_REDIV;
          end else if (stat.cnt_nonzero) begin
            cmd.emit_factor = 1'b1;
            if (stat.last_factor) begin
              state_next = tdf_pkg::ST_IDLE;
            end else begin
              cmd.next_d = 1'b1;
              state_next = tdf_pkg::ST_TEST;
            end
          end else begin
            cmd.next_d = 1'b1;
            state_next = tdf_pkg::ST_TEST;
          end
        end
      end
      tdf_pkg::ST_REDIV: begin
        cmd.div_start = 1'b1;
        state_next    = tdf_pkg::ST_DIV;
      end
      tdf_pkg::ST_FINAL: begin
        cmd.emit_cofactor = 1'b1;
        state_next        = tdf_pkg::ST_IDLE;
      end
      default: begin
        state_next = tdf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/trial_division_factorizer_top.sv
// Trial division factorizer: splits an unsigned value into its prime factors.
// A value is taken when start is high while busy is low. Each candidate
// divisor from 2 upward is compared by its square with the remaining value
// and, unless the square is larger, tried on the bit-serial divider; a prime
// that divides the value is divided out again until the remainder is
// non-zero. The value left when the square exceeds it is the last factor.
// An input of 0 or 1 is reported from the classify state with no division.
// Results appear one per strobe on valid in ascending order of prime, the
// final one with last set. The receiver cannot stall the block, so each
// result is present for a single cycle. The next value may be started in
// the cycle that carries the final result.
module trial_division_factorizer_top #(
  parameter int VALUE_WIDTH = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [VALUE_WIDTH-1:0]            value,
  output logic                              busy,
  output logic                              valid,
  output logic [tdf_pkg::PRIME_WIDTH-1:0]   prime,
  output logic [tdf_pkg::EXP_WIDTH-1:0]     exponent,
  output logic [tdf_pkg::STATUS_WIDTH-1:0]  status,
  output logic                              last
);

  localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;

  tdf_pkg::ctrl_cmd_t  cmd;
  tdf_pkg::dp_status_t stat;

  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [DIV_WIDTH-1:0]   remainder;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [DIV_WIDTH-1:0]   divisor;

  tdf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tdf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIV_WIDTH   (DIV_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .value     (value),
    .div_done  (div_done),
    .quotient  (quotient),
    .remainder (remainder),
    .dividend  (dividend),
    .divisor   (divisor),
    .valid     (valid),
    .prime     (prime),
    .exponent  (exponent),
    .status    (status),
    .last      (last)
  );

  tdf_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIV_WIDTH   (DIV_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

endmodule

>>> hw/rtl/tdf_checker.sv
// Port-level checker for the trial division factorizer and its bind statement.
`include "assert_macros.svh"

module tdf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              valid,
  input logic [tdf_pkg::PRIME_WIDTH-1:0]   prime,
  input logic [tdf_pkg::EXP_WIDTH-1:0]     exponent,
  input logic [tdf_pkg::STATUS_WIDTH-1:0]  status,
  input logic                              last
);

  localparam int PW = tdf_pkg::PRIME_WIDTH;

  logic special_res;
  logic factor_res;
  logic special_ok;
  logic factor_ok;
  logic status_known;
  logic accepted;

  assign special_res  = valid && (status != tdf_pkg::STATUS_OK);
  assign factor_res   = valid && (status == tdf_pkg::STATUS_OK);
  assign special_ok   = last && (prime == '0) && (exponent == '0);
  assign factor_ok    = (exponent != '0) && (prime >= PW'(2));
  assign status_known = (status == tdf_pkg::STATUS_OK) || (status == tdf_pkg::STATUS_NONE) ||
                        (status == tdf_pkg::STATUS_INVALID);
  assign accepted     = start && !busy;

  `ASSERT_SAME(a_special, clk, rst, special_res, special_ok, "bad special result")
  `ASSERT_SAME(a_factor, clk, rst, factor_res, factor_ok, "bad factor fields")
  `ASSERT_SAME(a_status, clk, rst, valid, status_known, "undefined status code")
  `ASSERT_SAME(a_busy_midrun, clk, rst, valid && !last, busy, "idle before final result")
  `ASSERT_NEXT(a_busy_after_start, clk, rst, accepted, busy, "transfer did not set busy")

endmodule

bind trial_division_factorizer_top tdf_checker u_tdf_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the trial division factorizer: random and directed values.
module tb_top;

  localparam int VALUE_W = 40;
  localparam int RANDOM_JOBS = 85;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [tdf_pkg::PRIME_WIDTH-1:0]  prime;
    logic [tdf_pkg::EXP_WIDTH-1:0]    exponent;
    logic [tdf_pkg::STATUS_WIDTH-1:0] status;
    logic                             last;
  } factor_t;

  typedef struct {
    logic [VALUE_W-1:0] v;
    bit                 drain;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic busy;
  logic valid;
  logic [tdf_pkg::PRIME_WIDTH-1:0] prime;
  logic [tdf_pkg::EXP_WIDTH-1:0] exponent;
  logic [tdf_pkg::STATUS_WIDTH-1:0] status;
  logic last;

  job_t pending_jobs[$];
  factor_t expected_factors[$];
  int total_jobs = 0;
  int jobs_accepted = 0;
  int errors = 0;
  int cycles = 0;

  trial_division_factorizer_top #(.VALUE_WIDTH(VALUE_W)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .value(value),
    .busy(busy),
    .valid(valid),
    .prime(prime),
    .exponent(exponent),
    .status(status),
    .last(last)
  );

  always #2 clk = ~clk;

  function automatic void predict_factorization(input logic [VALUE_W-1:0] v);
    factor_t run[tdf_pkg::MAX_RESULTS];
    longint unsigned rest;
    longint unsigned d;
    longint unsigned cnt;
    int n;
    rest = 64'(v);
    n = 0;
    if (rest == 0) begin
      run[0] = '{prime: '0, exponent: '0, status: tdf_pkg::STATUS_INVALID, last: 1'b0};
      n = 1;
    end else if (rest == 1) begin
      run[0] = '{prime: '0, exponent: '0, status: tdf_pkg::STATUS_NONE, last: 1'b0};
      n = 1;
    end else begin
      for (d = 2; d * d <= rest; d++) begin
        if (rest % d == 0) begin
          cnt = 0;
          while (rest % d == 0) begin
            rest = rest / d;
            cnt++;
          end
          if (n < tdf_pkg::MAX_RESULTS) begin
            run[n] = '{prime: tdf_pkg::PRIME_WIDTH'(d), exponent: tdf_pkg::EXP_WIDTH'(cnt),
                       status: tdf_pkg::STATUS_OK, last: 1'b0};
            n++;
          end
        end
      end
      if (rest != 1 && n < tdf_pkg::MAX_RESULTS) begin
        run[n] = '{prime: tdf_pkg::PRIME_WIDTH'(rest), exponent: tdf_pkg::EXP_WIDTH'(1),
                   status: tdf_pkg::STATUS_OK, last: 1'b0};
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      run[i].last = (i == n - 1);
      expected_factors = {expected_factors, run[i]};
    end
  endfunction

  always @(posedge clk) begin : driver
    int idle_pct;
    bit hold;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_factorization(value);
        jobs_accepted++;
      end
      if (!start || !busy) begin
        if (jobs_accepted < total_jobs / 3) begin
          idle_pct = 22;
        end else if (jobs_accepted < 2 * total_jobs / 3) begin
          idle_pct = 68;
        end else begin
          idle_pct = 0;
        end
        hold = pending_jobs.size() == 0 ||
               (pending_jobs[0].drain && expected_factors.size() != 0);
        if (!hold && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          value <= pending_jobs[0].v;
          pending_jobs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    factor_t want;
    if (!rst && valid) begin
      if (expected_factors.size() == 0) begin
        $display("%0t: unexpected transfer: prime %0d exponent %0d status %0d last %0d",
                 $time, prime, exponent, status, last);
        errors++;
      end else begin
        want = expected_factors.pop_front();
        if (prime !== want.prime || exponent !== want.exponent ||
            status !== want.status || last !== want.last) begin
          $display("%0t: expected prime %0d exponent %0d status %0d last %0d",
                   $time, want.prime, want.exponent, want.status, want.last);
          $display("%0t: actual   prime %0d exponent %0d status %0d last %0d",
                   $time, prime, exponent, status, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("trial_division_factorizer_top: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned directed[] = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd6, 64'd30,
      64'd549755813888, 64'd1099511627775, 64'd1099511627774,
      64'd847288609443, 64'd678223072849, 64'd200560490130,
      64'd16777213, 64'd1018081, 64'd1022117, 64'd65521, 64'd0, 64'd1
    };
    longint unsigned v;
    longint unsigned f;
    int nf;
    job_t job;
    foreach (directed[i]) begin
      job = '{v: VALUE_W'(directed[i]), drain: 1'b0};
      pending_jobs = {pending_jobs, job};
    end
    for (int k = 0; k < RANDOM_JOBS; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        v = 64'($urandom_range(0, 4095));
      end else begin
        v = 1;
        nf = int'($urandom_range(1, 16));
        repeat (nf) begin
          f = 64'($urandom_range(2, $urandom_range(2, 251)));
          if (v * f < (64'd1 << VALUE_W)) begin
            v = v * f;
          end
        end
        if ($urandom_range(0, 1) == 1) begin
          f = 64'($urandom_range(2, ($urandom_range(0, 7) == 0) ? 65535 : 4095));
          if (v * f < (64'd1 << VALUE_W)) begin
            v = v * f;
          end
        end
      end
      job = '{v: VALUE_W'(v), drain: (k == 0 || k == RANDOM_JOBS / 2)};
      pending_jobs = {pending_jobs, job};
    end
    total_jobs = pending_jobs.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (jobs_accepted < total_jobs || expected_factors.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("trial_division_factorizer_top: match");
    end else begin
      $display("trial_division_factorizer_top: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_div.sv
hw/rtl/tdf_datapath.sv
hw/rtl/tdf_ctrl.sv
hw/rtl/trial_division_factorizer_top.sv
hw/rtl/tdf_checker.sv
tb/tb_top.sv
